FILE: sv/tsf_pkg.sv
// Shared types and constants for the touch sample filter.
package tsf_pkg;

   localparam int SAMPLE_W             = 12;
   localparam int COORD_W              = 16;
   localparam int ERR_W                = 12;
   localparam int ATT_W                = 5;
   localparam int CSR_W                = 12;
   localparam int SAMPLES_PER_READ_DEF = 15;

   localparam logic [ERR_W-1:0]   TOL_RST       = 12'd50;
   localparam logic [ATT_W-1:0]   MAX_ATT_RST   = 5'd20;
   localparam logic [COORD_W-1:0] INVALID_COORD = 16'hFFFF;

   typedef enum logic {
      CSR_TOL          = 1'b0,
      CSR_MAX_ATTEMPTS = 1'b1
   } csr_idx_type;

   typedef enum logic {
      OP_SCAN   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      GRP_X1 = 2'd0,
      GRP_Y1 = 2'd1,
      GRP_X2 = 2'd2,
      GRP_Y2 = 2'd3
   } grp_type;

   typedef struct packed {
      logic    vld;
      grp_type grp;
   } grp_tag_type;

   typedef struct packed {
      logic               vld;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               ok;
   } result_type;

   typedef struct packed {
      logic fin;
      logic stop;
   } verdict_type;

endpackage

FILE: sv/tsf_if.sv
// Request and response channel interfaces for the touch sample filter.
interface tsf_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic        pen_down;
   logic [11:0] sample;

   modport source (output valid, output op, output pen_down, output sample, input ready);
   modport sink   (input valid, input op, input pen_down, input sample, output ready);
endinterface

interface tsf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] x_out;
   logic [15:0] y_out;
   logic        valid_res;

   modport source (output valid, output x_out, output y_out, output valid_res, input ready);
   modport sink   (input valid, input x_out, input y_out, input valid_res, output ready);
endinterface

FILE: sv/tsf_accum.sv
// Scan control and per-group sum, minimum and maximum accumulation.
module tsf_accum #(
   parameter int SPR = tsf_pkg::SAMPLES_PER_READ_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      acc,
   input  logic                                      op,
   input  logic                                      pen_down,
   input  logic [tsf_pkg::SAMPLE_W-1:0]              sample,
   input  tsf_pkg::verdict_type                      verdict,
   output logic                                      busy,
   output logic                                      scan_start,
   output tsf_pkg::result_type                       pen_up_res,
   output tsf_pkg::grp_tag_type                      tag,
   output logic [tsf_pkg::SAMPLE_W+$clog2(SPR)-1:0]  grp_sum,
   output logic [tsf_pkg::SAMPLE_W-1:0]              grp_min,
   output logic [tsf_pkg::SAMPLE_W-1:0]              grp_max
);
   import tsf_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(SPR);
   localparam int CNT_W = $clog2(SPR);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SPR - 1);

   logic                collect_ff, collect_in;
   logic                wait_ff, wait_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   grp_type             grp_ff, grp_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   grp_tag_type         tag_ff, tag_in;
   logic [SUM_W-1:0]    dsum_ff, dsum_in;
   logic [SAMPLE_W-1:0] dmin_ff, dmin_in;
   logic [SAMPLE_W-1:0] dmax_ff, dmax_in;

   logic [SUM_W-1:0]    s_sum;
   logic [SAMPLE_W-1:0] s_min, s_max;
   logic                take;

   always_comb begin
      s_sum = sum_ff + SUM_W'(sample);
      s_min = (sample < min_ff) ? sample : min_ff;
      s_max = (sample > max_ff) ? sample : max_ff;
      take  = acc && (op == OP_SAMPLE) && collect_ff;
   end

   always_comb begin
      collect_in = collect_ff;
      wait_in    = wait_ff;
      cnt_in     = cnt_ff;
      grp_in     = grp_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      tag_in     = '{vld: 1'b0, grp: grp_ff};
      dsum_in    = dsum_ff;
      dmin_in    = dmin_ff;
      dmax_in    = dmax_ff;
      if (verdict.fin) begin
         wait_in = 1'b0;
      end
      if (verdict.stop) begin
         collect_in = 1'b0;
      end
      if (acc && (op == OP_SCAN)) begin
         collect_in = pen_down;
         cnt_in     = '0;
         grp_in     = GRP_X1;
         sum_in     = '0;
         min_in     = '1;
         max_in     = '0;
      end else if (take) begin
         if (cnt_ff == CNT_LAST) begin
            tag_in  = '{vld: 1'b1, grp: grp_ff};
            dsum_in = s_sum;
            dmin_in = s_min;
            dmax_in = s_max;
            cnt_in  = '0;
            grp_in  = grp_type'(grp_ff + 2'd1);
            sum_in  = '0;
            min_in  = '1;
            max_in  = '0;
            if (grp_ff == GRP_Y2) begin
               wait_in = 1'b1;
            end
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            sum_in = s_sum;
            min_in = s_min;
            max_in = s_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collect_ff <= 1'b0;
         wait_ff    <= 1'b0;
         cnt_ff     <= '0;
         grp_ff     <= GRP_X1;
         sum_ff     <= '0;
         min_ff     <= '1;
         max_ff     <= '0;
         tag_ff     <= '{vld: 1'b0, grp: GRP_X1};
      end else begin
         collect_ff <= collect_in;
         wait_ff    <= wait_in;
         cnt_ff     <= cnt_in;
         grp_ff     <= grp_in;
         sum_ff     <= sum_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         tag_ff     <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      dsum_ff <= dsum_in;
      dmin_ff <= dmin_in;
      dmax_ff <= dmax_in;
   end

   always_comb begin
      busy       = wait_ff;
      scan_start = acc && (op == OP_SCAN);
      pen_up_res = '{vld: scan_start && !pen_down, x: INVALID_COORD,
                     y: INVALID_COORD, ok: 1'b0};
      tag        = tag_ff;
      grp_sum    = dsum_ff;
      grp_min    = dmin_ff;
      grp_max    = dmax_ff;
   end

endmodule

FILE: sv/tsf_mean.sv
// Trimmed group sum and division by the kept sample count via reciprocal multiply.
module tsf_mean #(
   parameter int SPR = tsf_pkg::SAMPLES_PER_READ_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  tsf_pkg::grp_tag_type                      tag_i,
   input  logic [tsf_pkg::SAMPLE_W+$clog2(SPR)-1:0]  grp_sum,
   input  logic [tsf_pkg::SAMPLE_W-1:0]              grp_min,
   input  logic [tsf_pkg::SAMPLE_W-1:0]              grp_max,
   output tsf_pkg::grp_tag_type                      tag_o,
   output logic [tsf_pkg::SAMPLE_W-1:0]              mean
);
   import tsf_pkg::*;

   localparam int     SUM_W   = SAMPLE_W + $clog2(SPR);
   localparam int     DIV     = SPR - 2;
   localparam int     SHIFT   = SUM_W + $clog2(DIV);
   localparam int     RECIP_W = SUM_W + 1;
   localparam int     PROD_W  = SUM_W + RECIP_W;
   localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIV) - 1) / longint'(DIV);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   logic [SUM_W-1:0]  trim;
   logic [PROD_W-1:0] prod_ff, prod_in;
   grp_tag_type       tag_ff;

   always_comb begin
      trim    = grp_sum - SUM_W'(grp_min) - SUM_W'(grp_max);
      prod_in = PROD_W'(trim) * PROD_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '{vld: 1'b0, grp: GRP_X1};
      end else begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign tag_o = tag_ff;
   assign mean  = prod_ff[SHIFT +: SAMPLE_W];

endmodule

FILE: sv/tsf_judge.sv
// Reading storage, agreement check, retry count and coordinate result.
module tsf_judge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          scan_start,
   input  tsf_pkg::grp_tag_type          tag,
   input  logic [tsf_pkg::SAMPLE_W-1:0]  mean,
   input  logic [tsf_pkg::ERR_W-1:0]     tol,
   input  logic [tsf_pkg::ATT_W-1:0]     max_att,
   output tsf_pkg::result_type           res,
   output tsf_pkg::verdict_type          verdict
);
   import tsf_pkg::*;

   logic [SAMPLE_W-1:0] first_x_ff, first_y_ff, second_x_ff;
   logic [ATT_W-1:0]    att_ff, att_in;

   logic [SAMPLE_W-1:0] diff_x, diff_y;
   logic [SAMPLE_W:0]   sum_x, sum_y;
   logic [ATT_W-1:0]    att_inc;
   logic                agree, give_up, fin;

   always_comb begin
      diff_x  = (first_x_ff >= second_x_ff) ? first_x_ff - second_x_ff
                                            : second_x_ff - first_x_ff;
      diff_y  = (first_y_ff >= mean) ? first_y_ff - mean : mean - first_y_ff;
      agree   = (diff_x < tol) && (diff_y < tol);
      sum_x   = {1'b0, first_x_ff} + {1'b0, second_x_ff};
      sum_y   = {1'b0, first_y_ff} + {1'b0, mean};
      att_inc = att_ff + ATT_W'(1);
      give_up = (att_inc == '0) || (att_inc >= max_att);
      fin     = tag.vld && (tag.grp == GRP_Y2);
   end

   always_comb begin
      verdict.fin  = fin;
      verdict.stop = fin && (agree || give_up);
      res.vld      = verdict.stop;
      res.ok       = agree;
      res.x        = agree ? COORD_W'(sum_x[SAMPLE_W:1]) : INVALID_COORD;
      res.y        = agree ? COORD_W'(sum_y[SAMPLE_W:1]) : INVALID_COORD;
   end

   always_comb begin
      att_in = att_ff;
      if (scan_start) begin
         att_in = '0;
      end else if (fin) begin
         att_in = (agree || give_up) ? '0 : att_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         att_ff <= '0;
      end else begin
         att_ff <= att_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tag.vld) begin
         case (tag.grp)
            GRP_X1: begin
               first_x_ff <= mean;
            end
            GRP_Y1: begin
               first_y_ff <= mean;
            end
            GRP_X2: begin
               second_x_ff <= mean;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: sv/tsf_rspq.sv
// Response output register with one skid entry.
module tsf_rspq (
   input  logic                clock,
   input  logic                reset,
   input  tsf_pkg::result_type push,
   input  logic                pop,
   output tsf_pkg::result_type head,
   output logic                full
);
   import tsf_pkg::*;

   result_type out_ff, out_in;
   result_type skid_ff, skid_in;

   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (!out_ff.vld || pop) begin
         if (skid_ff.vld) begin
            out_in  = skid_ff;
            skid_in = push;
         end else begin
            out_in = push;
         end
      end else if (push.vld) begin
         skid_in = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld  <= 1'b0;
         skid_ff.vld <= 1'b0;
      end else begin
         out_ff.vld  <= out_in.vld;
         skid_ff.vld <= skid_in.vld;
      end
      out_ff.x   <= out_in.x;
      out_ff.y   <= out_in.y;
      out_ff.ok  <= out_in.ok;
      skid_ff.x  <= skid_in.x;
      skid_ff.y  <= skid_in.y;
      skid_ff.ok <= skid_in.ok;
   end

   assign head = out_ff;
   assign full = skid_ff.vld;

endmodule

FILE: sv/touch_sample_filter_core.sv
// Touch sample filter: trimmed-mean X/Y filtering with agreement check and retries.
// Throughput: one word per cycle, except while the agreement check resolves after the last
// sample of an attempt, and while the skid entry is full.
// A pen-up scan start is answered at acceptance and registered in the response queue; an
// attempt's result passes the group registers, the mean product register and the response queue.
// Reset is synchronous; registers return to tolerance 50, max_attempts 20, idle.
module touch_sample_filter_core #(
   parameter int SPR = tsf_pkg::SAMPLES_PER_READ_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   tsf_req_if.sink                   req_if,
   tsf_rsp_if.source                 rsp_if,
   input  logic                      csr_we,
   input  logic                      csr_idx,
   input  logic [tsf_pkg::CSR_W-1:0] csr_wdata
);
   import tsf_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(SPR);

   logic [ERR_W-1:0] tol_ff;
   logic [ATT_W-1:0] max_att_ff;

   logic                acc, busy, scan_start, q_full, pop;
   result_type          pen_up_res, judge_res, push, head;
   verdict_type         verdict;
   grp_tag_type         tag_a, tag_b;
   logic [SUM_W-1:0]    grp_sum;
   logic [SAMPLE_W-1:0] grp_min, grp_max, mean;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff     <= TOL_RST;
         max_att_ff <= MAX_ATT_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_TOL: begin
               tol_ff <= csr_wdata[ERR_W-1:0];
            end
            CSR_MAX_ATTEMPTS: begin
               max_att_ff <= csr_wdata[ATT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_if.ready = !busy && !q_full;
   assign acc          = req_if.valid && req_if.ready;
   assign pop          = rsp_if.valid && rsp_if.ready;
   assign push         = judge_res.vld ? judge_res : pen_up_res;

   tsf_accum #(.SPR(SPR)) u_accum (
      .clock      (clock),
      .reset      (reset),
      .acc        (acc),
      .op         (req_if.op),
      .pen_down   (req_if.pen_down),
      .sample     (req_if.sample),
      .verdict    (verdict),
      .busy       (busy),
      .scan_start (scan_start),
      .pen_up_res (pen_up_res),
      .tag        (tag_a),
      .grp_sum    (grp_sum),
      .grp_min    (grp_min),
      .grp_max    (grp_max)
   );

   tsf_mean #(.SPR(SPR)) u_mean (
      .clock   (clock),
      .reset   (reset),
      .tag_i   (tag_a),
      .grp_sum (grp_sum),
      .grp_min (grp_min),
      .grp_max (grp_max),
      .tag_o   (tag_b),
      .mean    (mean)
   );

   tsf_judge u_judge (
      .clock      (clock),
      .reset      (reset),
      .scan_start (scan_start),
      .tag        (tag_b),
      .mean       (mean),
      .tol        (tol_ff),
      .max_att    (max_att_ff),
      .res        (judge_res),
      .verdict    (verdict)
   );

   tsf_rspq u_rspq (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   assign rsp_if.valid     = head.vld;
   assign rsp_if.x_out     = head.x;
   assign rsp_if.y_out     = head.y;
   assign rsp_if.valid_res = head.ok;

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.vld |-> !q_full)
      else $error("result word pushed while skid entry occupied");

   a_no_double_push: assert property (@(posedge clock) disable iff (reset)
      !(judge_res.vld && pen_up_res.vld))
      else $error("two result sources in the same cycle");

   a_attempt_resolves: assert property (@(posedge clock) disable iff (reset)
      (tag_a.vld && tag_a.grp == GRP_Y2) |-> ##1 verdict.fin)
      else $error("attempt end did not reach the agreement check");

   a_valid_coord_range: assert property (@(posedge clock) disable iff (reset)
      (judge_res.vld && judge_res.ok) |-> (judge_res.x[COORD_W-1:SAMPLE_W] == '0
         && judge_res.y[COORD_W-1:SAMPLE_W] == '0))
      else $error("valid coordinate out of sample range");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Bench for touch_sample_filter_core: directed and random scans against a filter predictor.
module tb_top;
   import tsf_pkg::*;

   localparam int SPR = SAMPLES_PER_READ_DEF;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               ok;
   } coord_word_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   csr_idx_type         csr_idx;
   logic [CSR_W-1:0]    csr_wdata;

   tsf_req_if req_ch ();
   tsf_rsp_if rsp_ch ();

   touch_sample_filter_core #(.SPR(SPR)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   coord_word_type expected_coords[$];
   int             send_idle_pct;
   int             stall_pct;
   int             mismatches;
   int             words_taken;
   int             coords_seen;

   // filter state mirror
   logic [ERR_W-1:0]                 flt_tol;
   logic [ATT_W-1:0]                 flt_max_att;
   logic                             flt_busy;
   int                               flt_count;
   logic [SAMPLE_W+$clog2(SPR)-1:0]  flt_sum;
   logic [SAMPLE_W-1:0]              flt_lo;
   logic [SAMPLE_W-1:0]              flt_hi;
   logic [SAMPLE_W-1:0]              flt_x1;
   logic [SAMPLE_W-1:0]              flt_y1;
   logic [SAMPLE_W-1:0]              flt_x2;
   logic [ATT_W-1:0]                 flt_tries;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("touch_sample_filter_core: mismatch");
      $finish;
   end

   function automatic bit readings_agree(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
      return ((a >= b) ? a - b : b - a) < flt_tol;
   endfunction

   function automatic void clear_group();
      flt_sum = '0;
      flt_lo  = '1;
      flt_hi  = '0;
   endfunction

   task automatic predict_coords(op_type op, logic pen, logic [SAMPLE_W-1:0] smp);
      logic [SAMPLE_W-1:0] mean;
      if (op == OP_SCAN) begin
         clear_group();
         flt_count = 0;
         flt_tries = '0;
         flt_busy  = pen;
         if (!pen)
            expected_coords.push_back(
               coord_word_type'{x: INVALID_COORD, y: INVALID_COORD, ok: 1'b0});
         return;
      end
      if (!flt_busy)
         return;
      flt_sum = flt_sum + smp;
      if (smp < flt_lo)
         flt_lo = smp;
      if (smp > flt_hi)
         flt_hi = smp;
      flt_count++;
      if (flt_count % SPR != 0)
         return;
      mean = SAMPLE_W'((flt_sum - flt_lo - flt_hi) / (SPR - 2));
      clear_group();
      case (grp_type'(flt_count / SPR - 1))
         GRP_X1: flt_x1 = mean;
         GRP_Y1: flt_y1 = mean;
         GRP_X2: flt_x2 = mean;
         default: begin
            flt_count = 0;
            if (readings_agree(flt_x1, flt_x2) && readings_agree(flt_y1, mean)) begin
               flt_busy  = 1'b0;
               flt_tries = '0;
               expected_coords.push_back(coord_word_type'{
                  x:  (COORD_W'(flt_x1) + flt_x2) >> 1,
                  y:  (COORD_W'(flt_y1) + mean) >> 1,
                  ok: 1'b1});
            end else begin
               flt_tries = flt_tries + 1'b1;
               if (flt_tries == 0 || flt_tries >= flt_max_att) begin
                  flt_busy  = 1'b0;
                  flt_tries = '0;
                  expected_coords.push_back(
                     coord_word_type'{x: INVALID_COORD, y: INVALID_COORD, ok: 1'b0});
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      coord_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         coords_seen++;
         if (expected_coords.size() == 0) begin
            $error("unexpected word: x_out %0d y_out %0d valid_res %0d",
                   rsp_ch.x_out, rsp_ch.y_out, rsp_ch.valid_res);
            mismatches++;
         end else begin
            want = expected_coords.pop_front();
            if (rsp_ch.x_out !== want.x) begin
               $error("x_out: expected %0d, got %0d", want.x, rsp_ch.x_out);
               mismatches++;
            end
            if (rsp_ch.y_out !== want.y) begin
               $error("y_out: expected %0d, got %0d", want.y, rsp_ch.y_out);
               mismatches++;
            end
            if (rsp_ch.valid_res !== want.ok) begin
               $error("valid_res: expected %0d, got %0d", want.ok, rsp_ch.valid_res);
               mismatches++;
            end
         end
      end
   end

   // leaves valid high; the next call or go_idle decides what follows
   task automatic send_word(op_type op, logic pen, logic [SAMPLE_W-1:0] smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.op       = op;
      req_ch.pen_down = pen;
      req_ch.sample   = smp;
      do @(posedge clock); while (!req_ch.ready);
      if (op == OP_SCAN || flt_busy)
         words_taken++;
      predict_coords(op, pen, smp);
      @(negedge clock);
   endtask

   task automatic send_group(int center, int spread, int outlier_pct);
      int v;
      repeat (SPR) begin
         v = center + int'($urandom_range(spread)) - spread / 2;
         if (v < 0)
            v = 0;
         if (v > 4095)
            v = 4095;
         if ($urandom_range(99) < outlier_pct)
            v = $urandom_range(4095);
         send_word(OP_SAMPLE, 1'($urandom_range(1)), v[SAMPLE_W-1:0]);
      end
   endtask

   task automatic send_attempt(int cx, int cy, int spread, int shift, int outlier_pct);
      send_group(cx, spread, outlier_pct);
      send_group(cy, spread, outlier_pct);
      send_group(cx + shift, spread, outlier_pct);
      send_group(cy - shift, spread, outlier_pct);
   endtask

   task automatic go_idle();
      if (flt_busy)
         send_word(OP_SCAN, 1'b0, SAMPLE_W'($urandom_range(4095)));
      req_ch.valid = 1'b0;
      while (expected_coords.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CSR_W-1:0] data);
      csr_we    = 1'b1;
      csr_idx   = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_TOL)
         flt_tol = data[ERR_W-1:0];
      else
         flt_max_att = data[ATT_W-1:0];
   endtask

   task automatic run_scan();
      int kind;
      int cx;
      int cy;
      int m;
      kind = $urandom_range(99);
      cx   = $urandom_range(4095);
      cy   = $urandom_range(4095);
      if (kind < 8) begin
         send_word(OP_SCAN, 1'b0, SAMPLE_W'($urandom_range(4095)));
      end else if (kind < 12) begin
         repeat ($urandom_range(1, 3))
            send_word(OP_SAMPLE, 1'($urandom_range(1)), SAMPLE_W'($urandom_range(4095)));
      end else begin
         send_word(OP_SCAN, 1'b1, SAMPLE_W'($urandom_range(4095)));
         while (flt_busy) begin
            m = $urandom_range(19);
            if (m == 0) begin
               // broken scan: cut short, the next scan start abandons it
               repeat ($urandom_range(1, 4 * SPR - 1))
                  send_word(OP_SAMPLE, 1'($urandom_range(1)),
                            SAMPLE_W'($urandom_range(4095)));
               return;
            end
            if (m < 8)
               send_attempt(cx, cy, 0, 0, 0);
            else if (m < 14)
               send_attempt(cx, cy, 16, $urandom_range(8), 5);
            else if (m < 18)
               send_attempt(cx, cy, 300, $urandom_range(60), 5);
            else
               send_attempt(cx, cy, 40, $urandom_range(4095), 0);
         end
      end
   endtask

   task automatic test_pen_up_and_idle();
      send_word(OP_SCAN, 1'b0, 12'hFFF);
      send_word(OP_SAMPLE, 1'b1, 12'h000);
      send_word(OP_SAMPLE, 1'b0, 12'hFFF);
      send_word(OP_SCAN, 1'b0, 12'h000);
      go_idle();
   endtask

   task automatic test_extreme_groups();
      send_word(OP_SCAN, 1'b1, 12'h000);
      send_attempt(4095, 4095, 0, 0, 0);
      send_word(OP_SCAN, 1'b1, 12'hFFF);
      send_attempt(0, 0, 0, 0, 0);
      send_word(OP_SCAN, 1'b1, 12'h000);
      send_attempt(0, 4095, 0, 0, 0);
      send_word(OP_SCAN, 1'b1, 12'h000);
      send_attempt(2000, 1000, 4095, 0, 0);
      go_idle();
   endtask

   task automatic test_scan_restart();
      send_word(OP_SCAN, 1'b1, 12'h000);
      send_group(700, 0, 0);
      send_group(900, 20, 0);
      send_word(OP_SCAN, 1'b1, 12'h000);
      send_attempt(1234, 3210, 10, 2, 0);
      send_word(OP_SCAN, 1'b1, 12'h000);
      send_group(100, 4, 0);
      send_word(OP_SCAN, 1'b0, 12'h000);
      go_idle();
   endtask

   task automatic test_retry_limits();
      write_csr(CSR_TOL, 12'd0);
      write_csr(CSR_MAX_ATTEMPTS, 12'd0);
      send_word(OP_SCAN, 1'b1, 12'h000);
      send_attempt(500, 500, 0, 0, 0);
      go_idle();
      write_csr(CSR_MAX_ATTEMPTS, 12'd2);
      send_word(OP_SCAN, 1'b1, 12'h000);
      send_attempt(800, 300, 0, 0, 0);
      send_attempt(800, 300, 0, 0, 0);
      go_idle();
      write_csr(CSR_TOL, 12'd1);
      send_word(OP_SCAN, 1'b1, 12'h000);
      send_attempt(3000, 17, 0, 0, 0);
      go_idle();
      write_csr(CSR_TOL, 12'd4095);
      write_csr(CSR_MAX_ATTEMPTS, 12'd31);
      send_word(OP_SCAN, 1'b1, 12'h000);
      send_attempt(0, 100, 0, 4095, 0);
      send_attempt(60, 4000, 0, 0, 0);
      go_idle();
   endtask

   task automatic test_random_traffic(int idle_pct, int stall, int err, int att);
      int words0;
      int coords0;
      go_idle();
      write_csr(CSR_TOL, CSR_W'(err));
      write_csr(CSR_MAX_ATTEMPTS, CSR_W'(att));
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      words0        = words_taken;
      coords0       = coords_seen;
      while (words_taken - words0 < 220 || coords_seen - coords0 < 12)
         run_scan();
      go_idle();
   endtask

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_idx         = CSR_TOL;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.op       = OP_SCAN;
      req_ch.pen_down = 1'b0;
      req_ch.sample   = '0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      mismatches      = 0;
      words_taken     = 0;
      coords_seen     = 0;
      flt_tol         = TOL_RST;
      flt_max_att     = MAX_ATT_RST;
      flt_busy        = 1'b0;
      flt_count       = 0;
      flt_x1          = '0;
      flt_y1          = '0;
      flt_x2          = '0;
      flt_tries       = '0;
      clear_group();
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_pen_up_and_idle();
      test_extreme_groups();
      test_scan_restart();
      test_retry_limits();
      test_random_traffic(0, 0, 4095, 31);
      test_random_traffic(49, 0, 1, 1);
      test_random_traffic(0, 49, $urandom_range(20, 200), $urandom_range(1, 4));
      test_random_traffic(37, 37, $urandom_range(1, 4095), $urandom_range(2, 6));

      req_ch.valid = 1'b0;
      while (expected_coords.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("touch_sample_filter_core: match");
      else
         $display("touch_sample_filter_core: mismatch");
      $finish;
   end

endmodule
